[rtl/core/tips_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tips_pkg
// Shared constants and types for the threshold interval pixel sort unit.
// ----------------------------------------------------------------------------
package tips_pkg;
    localparam int RUN_DEPTH_DEF = 63;
    localparam logic [1:0] MODE_LUMA = 2'd0;
    localparam logic [1:0] MODE_HUE  = 2'd1;
    localparam logic [1:0] MODE_SAT  = 2'd2;
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_LOW  = 2'd1;
    localparam logic [1:0] REG_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic key_start;
        logic ins_start;
        logic ins_step;
        logic drain_step;
        logic pass_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic key_done;
        logic admit;
        logic ins_done;
        logic full;
        logic empty;
        logic drain_last;
        logic line_end;
    } t_sts;
endpackage
`default_nettype wire

[rtl/core/tips_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tips_div
// Restoring divider, one quotient bit a cycle, 35-bit dividend by 11-bit divisor.
// The top 11 dividend bits must be below the divisor, so the quotient is 24 bits.
// ----------------------------------------------------------------------------
module tips_div import tips_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [34:0] i_num,
    input  wire logic [10:0] i_den,
    output logic             o_done,
    output logic [23:0]      o_quot
);
    logic [23:0] r_q, n_q;
    logic [11:0] r_rem, n_rem;
    logic [10:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [11:0] w_try;

    always_comb begin
        w_try = {r_rem[10:0], r_q[23]};
        n_q   = {r_q[22:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd24;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_q   <= i_num[23:0];
            r_rem <= {1'b0, i_num[34:24]};
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = n_q;
endmodule
`default_nettype wire

[rtl/core/tips_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tips_datapath
// Key computation, sorted run store with one-step-a-cycle insertion, drain.
// ----------------------------------------------------------------------------
module tips_datapath import tips_pkg::*; #(
    parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_sts            o_sts,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_low,
    input  wire logic [7:0] i_high,
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [7:0] i_alpha,
    input  wire logic       i_line_end,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic [7:0]      o_alpha
);
    localparam int AW = $clog2(RUN_DEPTH + 1);
    localparam int IW = $clog2(RUN_DEPTH);

    logic [31:0] r_px;
    logic        r_le;
    logic [23:0] r_key, n_key;
    logic        r_kdone;
    logic [1:0]  r_kphase;
    logic [7:0]  w_mx, w_mn, w_d;
    logic [10:0] w_n;
    logic [34:0] w_num;
    logic [10:0] w_den;
    logic        w_dstart, w_ddone;
    logic [23:0] w_quot;
    logic [31:0] r_luma;

    logic [31:0] r_pix [RUN_DEPTH];
    logic [23:0] r_keys [RUN_DEPTH];
    logic [AW-1:0] r_len, r_pos, r_rd;
    logic [31:0] r_out;
    logic        r_idone;
    logic [23:0] r_kprev;
    logic [31:0] r_pprev;
    logic        w_shift;

    always_comb begin
        w_mx = (r_px[7:0] > r_px[15:8]) ? ((r_px[7:0] > r_px[23:16]) ? r_px[7:0] : r_px[23:16])
             : ((r_px[15:8] > r_px[23:16]) ? r_px[15:8] : r_px[23:16]);
        w_mn = (r_px[7:0] < r_px[15:8]) ? ((r_px[7:0] < r_px[23:16]) ? r_px[7:0] : r_px[23:16])
             : ((r_px[15:8] < r_px[23:16]) ? r_px[15:8] : r_px[23:16]);
        w_d = w_mx - w_mn;
        if (w_mx == r_px[7:0]) begin
            w_n = {3'd0, r_px[15:8]} - {3'd0, r_px[23:16]};
            if (r_px[15:8] < r_px[23:16]) w_n = w_n + 11'(6 * w_d);
        end else if (w_mx == r_px[15:8]) begin
            w_n = {3'd0, r_px[23:16]} - {3'd0, r_px[7:0]} + {2'd0, w_d, 1'b0};
        end else begin
            w_n = {3'd0, r_px[7:0]} - {3'd0, r_px[15:8]} + {1'b0, w_d, 2'd0};
        end
        if (i_mode == MODE_HUE) begin
            w_num = {19'(w_n * 19'd255), 16'd0};
            w_den = 11'(6 * w_d);
        end else begin
            w_num = {3'd0, 16'(w_d * 16'd255), 16'd0};
            w_den = {3'd0, w_mx};
        end
    end

    assign w_dstart = (r_kphase == 2'd1) &&
        ((i_mode == MODE_HUE && w_d != 8'd0) || (i_mode == MODE_SAT && w_mx != 8'd0));

    tips_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kphase <= 2'd0;
            r_kdone  <= 1'b0;
        end else begin
            r_kdone <= 1'b0;
            if (i_cmd.key_start) r_kphase <= 2'd1;
            else if (r_kphase == 2'd1) begin
                if (w_dstart) r_kphase <= 2'd2;
                else begin
                    r_kphase <= 2'd0;
                    r_kdone  <= 1'b1;
                end
            end else if (r_kphase == 2'd2 && w_ddone) begin
                r_kphase <= 2'd0;
                r_kdone  <= 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_px <= {i_alpha, i_blue, i_green, i_red};
            r_le <= i_line_end;
            r_luma <= 32'(i_red) * 32'd13933 + 32'(i_green) * 32'd46871
                    + 32'(i_blue) * 32'd4732;
        end
        if (r_kphase == 2'd1 && !w_dstart)
            r_key <= (i_mode == MODE_HUE || i_mode == MODE_SAT) ? 24'd0 : r_luma[23:0];
        else if (r_kphase == 2'd2 && w_ddone)
            r_key <= w_quot;
    end

    assign n_key = r_key;
    assign o_sts.key_done = r_kdone;
    assign o_sts.admit = (n_key >= {i_low, 16'd0}) && (n_key <= {i_high, 16'd0});

    assign w_shift = (r_pos != '0) && (r_kprev > r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_idone <= 1'b0;
        end else begin
            r_idone <= 1'b0;
            if (i_cmd.clear) r_len <= '0;
            else if (i_cmd.ins_step && !w_shift) begin
                r_len   <= r_len + AW'(1);
                r_idone <= 1'b1;
            end
        end
        if (i_cmd.ins_start) begin
            r_pos <= r_len;
            if (r_len != '0) begin
                r_kprev <= r_keys[IW'(r_len - AW'(1))];
                r_pprev <= r_pix[IW'(r_len - AW'(1))];
            end
        end else if (i_cmd.ins_step) begin
            if (w_shift) begin
                r_keys[IW'(r_pos)] <= r_kprev;
                r_pix[IW'(r_pos)]  <= r_pprev;
                r_pos <= r_pos - AW'(1);
                if (r_pos > AW'(1)) begin
                    r_kprev <= r_keys[IW'(r_pos - AW'(2))];
                    r_pprev <= r_pix[IW'(r_pos - AW'(2))];
                end
            end else begin
                r_keys[IW'(r_pos)] <= r_key;
                r_pix[IW'(r_pos)]  <= r_px;
            end
        end
        if (i_cmd.clear || i_cmd.load) r_rd <= '0;
        else if (i_cmd.drain_step) r_rd <= r_rd + AW'(1);
        if (i_cmd.drain_step) r_out <= r_pix[IW'(r_rd)];
        else if (i_cmd.pass_out) r_out <= r_px;
    end

    assign o_sts.ins_done   = r_idone;
    assign o_sts.full       = (r_len == AW'(RUN_DEPTH));
    assign o_sts.empty      = (r_len == '0);
    assign o_sts.drain_last = (r_rd + AW'(1) == r_len);
    assign o_sts.line_end   = r_le;
    assign {o_alpha, o_blue, o_green, o_red} = r_out;
endmodule
`default_nettype wire

[rtl/core/tips_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tips_ctrl
// Sequencer: key, admit test, insertion, drain and pass-through; output handshake.
// ----------------------------------------------------------------------------
module tips_ctrl import tips_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic      o_line_end,
    output logic      o_batch_last,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_DRN  = 3'd3;
    localparam logic [2:0] S_PASS = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] r_state, n_state;
    logic r_ov, r_le, r_bl, r_pass;
    logic w_free, w_acc, w_tail;

    assign w_free = !r_ov || !i_stall;
    assign w_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_cmd.load = w_acc;
        case (r_state)
            S_IDLE: if (w_acc) begin
                n_state = S_KEY;
                o_cmd.key_start = 1'b1;
            end
            S_KEY: if (i_sts.key_done) begin
                if (i_sts.admit) begin
                    n_state = S_INS;
                    o_cmd.ins_start = 1'b1;
                end else begin
                    n_state = i_sts.empty ? S_PASS : S_DRN;
                end
            end
            S_INS: begin
                o_cmd.ins_step = !i_sts.ins_done;
                if (i_sts.ins_done)
                    n_state = (i_sts.full || i_sts.line_end) ? S_DRN : S_IDLE;
            end
            S_DRN: if (w_free) begin
                o_cmd.drain_step = 1'b1;
                if (i_sts.drain_last) begin
                    o_cmd.clear = 1'b1;
                    n_state = r_pass ? S_PASS : S_WAIT;
                end
            end
            S_PASS: if (w_free) begin
                o_cmd.pass_out = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_tail = o_cmd.pass_out || (!r_pass && i_sts.drain_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pass  <= 1'b0;
            r_le    <= 1'b0;
            r_bl    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_KEY && i_sts.key_done) r_pass <= !i_sts.admit;
            if (o_cmd.drain_step || o_cmd.pass_out) begin
                r_ov <= 1'b1;
                r_bl <= w_tail;
                r_le <= w_tail && i_sts.line_end;
            end else if (!i_stall) r_ov <= 1'b0;
        end
    end

    assign o_valid      = r_ov;
    assign o_line_end   = r_le;
    assign o_batch_last = r_bl;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_bl)) else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !w_acc) else $error("request taken while busy");
    a_le_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_le |-> r_bl) else $error("line end off last result");
endmodule
`default_nettype wire

[rtl/core/threshold_interval_pixel_sort_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_interval_pixel_sort_unit
// Sorts threshold-bounded runs of pixels by luminance, hue or saturation key.
// Key: luma, or hue/saturation from the divider (zero for a zero divisor).
// Insertion shifts each larger stored pixel up one place, then writes the new one.
// One request at a time. A rejected pixel, or an admitted one that fills the run
// or ends the line, drains the run, one result a cycle unless the output stalls.
// Reset: synchronous active low, run empty, mode luma, thresholds 60 and 200.
// ----------------------------------------------------------------------------
module threshold_interval_pixel_sort_unit import tips_pkg::*; #(
    parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_alpha_in,
    input  wire logic        i_line_end_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_alpha_out,
    output logic             o_line_end_out,
    output logic             o_batch_last
);
    logic [1:0] r_mode;
    logic [7:0] r_low, r_high;
    t_cmd w_cmd;
    t_sts w_sts;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LUMA;
            r_low  <= 8'd60;
            r_high <= 8'd200;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MODE: r_mode <= pwdata[1:0];
                REG_LOW:  r_low  <= pwdata[7:0];
                REG_HIGH: r_high <= pwdata[7:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_MODE: prdata = {30'd0, r_mode};
            REG_LOW:  prdata = {24'd0, r_low};
            REG_HIGH: prdata = {24'd0, r_high};
            default:  prdata = 32'd0;
        endcase
    end

    tips_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_line_end(o_line_end_out),
        .o_batch_last(o_batch_last), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    tips_datapath #(.RUN_DEPTH(RUN_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode(r_mode), .i_low(r_low), .i_high(r_high),
        .i_red(i_red_in), .i_green(i_green_in), .i_blue(i_blue_in),
        .i_alpha(i_alpha_in), .i_line_end(i_line_end_in),
        .o_red(o_red_out), .o_green(o_green_out), .o_blue(o_blue_out),
        .o_alpha(o_alpha_out)
    );
endmodule
`default_nettype wire
